### rtl/core/bba_pkg.sv
// ---------------------------------------------------------------------------
// bba_pkg
// Field widths, command and status codes and the beat types shared by the
// bitmap block allocator.
// ---------------------------------------------------------------------------
package bba_pkg;

    localparam int CMD_W = 3;
    localparam int IDX_W = 17;
    localparam int CNT_W = 18;
    localparam int ST_W  = 2;

    localparam logic [CMD_W-1:0] CMD_FORMAT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MARK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TEST    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ENOUGH  = 3'd5;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_SHORT = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CNT_W-1:0] RESERVED_RESET = 18'd13;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] block_index;
        logic [CNT_W-1:0] required_count;
    } item_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] allocated_index;
        logic             bit_value;
        logic [CNT_W-1:0] free_blocks;
    } result_t;

endpackage

### rtl/core/bba_ram.sv
// ---------------------------------------------------------------------------
// bba_ram
// Generic single-clock RAM, one write port and one read port, registered
// read data (read-first on a same-address collision).
// ---------------------------------------------------------------------------
module bba_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/bba_ctrl.sv
// ---------------------------------------------------------------------------
// bba_ctrl
// Command sequencer: map sweep for format and reset, first-fit word scan from
// a lowest-free hint, and read-modify-write of single map bits.
// ---------------------------------------------------------------------------
module bba_ctrl
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = 131072,
    parameter int WORD_BITS  = 32,
    localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS,
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  item_t                item,
    input  logic [CNT_W-1:0]     reserved_blocks,
    output logic                 res_valid,
    input  logic                 res_ready,
    output result_t              res,
    output logic                 mem_we,
    output logic [AW-1:0]        mem_waddr,
    output logic [WORD_BITS-1:0] mem_wdata,
    output logic [AW-1:0]        mem_raddr,
    input  logic [WORD_BITS-1:0] mem_rdata
);

    localparam int BW         = $clog2(WORD_BITS);
    localparam int CW         = $clog2(NUM_BLOCKS + 1);
    localparam int BASE_W     = $clog2(NUM_BLOCKS + WORD_BITS + 1);
    localparam int SHIFT      = IDX_W + BW;
    localparam longint RECIP  = ((longint'(1) << SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int LAST_VALID = NUM_BLOCKS - (MAP_WORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] ALL_ONES = '1;
    localparam logic [WORD_BITS-1:0] PAD_MASK =
        (LAST_VALID == WORD_BITS) ? '0 : (ALL_ONES << LAST_VALID);
    localparam logic [AW-1:0]     LAST_WORD  = AW'(MAP_WORDS - 1);
    localparam logic [CW-1:0]     FULL_COUNT = CW'(NUM_BLOCKS);
    localparam logic [BASE_W-1:0] WORD_STEP  = BASE_W'(WORD_BITS);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SWEEP   = 7'b0000010,
        S_SCAN    = 7'b0000100,
        S_DIV     = 7'b0001000,
        S_BIT_RD  = 7'b0010000,
        S_BIT_MOD = 7'b0100000,
        S_FIN     = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic              init_reg, init_next;
    logic [CW-1:0]     lim_reg, lim_next;
    logic [AW-1:0]     waddr_reg, waddr_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [AW-1:0]     hint_reg, hint_next;
    logic [BASE_W-1:0] hint_base_reg, hint_base_next;
    logic [CW-1:0]     free_reg, free_next;

    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [AW-1:0]     q_reg, q_next;
    logic [BW-1:0]     bsel_reg, bsel_next;
    logic [ST_W-1:0]   status_reg, status_next;
    logic [IDX_W-1:0]  granted_reg, granted_next;
    logic              bitv_reg, bitv_next;

    logic                 out_of_range;
    logic                 enough;
    logic [CW-1:0]        lim_in;
    logic [31:0]          base32, lim32, diff32;
    logic [WORD_BITS-1:0] sweep_pat;
    logic [WORD_BITS-1:0] word_pad, zeros, low_zero;
    logic [BW-1:0]        bit_idx;
    logic [31:0]          grant32;
    logic [63:0]          prod;
    logic [31:0]          rem32;
    logic [WORD_BITS-1:0] bit_mask;
    logic                 cur_bit;
    logic [31:0]          free32;
    logic [31:0]          rel_base32;

    assign out_of_range = 32'(item.block_index) >= 32'(NUM_BLOCKS);
    assign enough       = 32'(free_reg) >= 32'(item.required_count);
    assign lim_in       = (32'(reserved_blocks) > 32'(NUM_BLOCKS)) ? FULL_COUNT
                                                                    : CW'(reserved_blocks);

    assign base32 = 32'(base_reg);
    assign lim32  = 32'(lim_reg);
    assign diff32 = lim32 - base32;

    always_comb
    begin
        if (base32 + 32'(WORD_BITS) <= lim32)
        begin
            sweep_pat = ALL_ONES;
        end
        else if (base32 >= lim32)
        begin
            sweep_pat = '0;
        end
        else
        begin
            sweep_pat = ~(ALL_ONES << diff32[BW-1:0]);
        end
    end

    // padding bits past the last block count as used
    assign word_pad = mem_rdata | ((waddr_reg == LAST_WORD) ? PAD_MASK : '0);
    assign zeros    = ~word_pad;
    assign low_zero = zeros & (~zeros + WORD_BITS'(1));

    always_comb
    begin
        bit_idx = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (low_zero[b])
            begin
                bit_idx = bit_idx | BW'(b);
            end
        end
    end

    assign grant32 = base32 + 32'(bit_idx);

    // word index by reciprocal multiply, exact over the index field range
    assign prod       = 64'(idx_reg) * 64'(RECIP);
    assign rem32      = 32'(idx_reg) - 32'(q_reg) * 32'(WORD_BITS);
    assign bit_mask   = WORD_BITS'(1) << bsel_reg;
    assign cur_bit    = mem_rdata[bsel_reg];
    assign rel_base32 = 32'(idx_reg) - 32'(bsel_reg);
    assign free32     = 32'(free_reg);

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_FIN);
    assign res.status          = status_reg;
    assign res.allocated_index = granted_reg;
    assign res.bit_value       = bitv_reg;
    assign res.free_blocks     = free32[CNT_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        lim_next       = lim_reg;
        waddr_next     = waddr_reg;
        base_next      = base_reg;
        hint_next      = hint_reg;
        hint_base_next = hint_base_reg;
        free_next      = free_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        q_next         = q_reg;
        bsel_next      = bsel_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        bitv_next      = bitv_reg;
        mem_we         = 1'b0;
        mem_waddr      = waddr_reg;
        mem_wdata      = '0;
        mem_raddr      = waddr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                mem_raddr = hint_reg;
                if (in_valid)
                begin
                    cmd_next     = item.cmd;
                    idx_next     = item.block_index;
                    status_next  = ST_OK;
                    granted_next = '0;
                    bitv_next    = 1'b0;
                    unique case (item.cmd) inside
                        CMD_FORMAT:
                        begin
                            lim_next       = lim_in;
                            waddr_next     = '0;
                            base_next      = '0;
                            hint_next      = '0;
                            hint_base_next = '0;
                            state_next     = S_SWEEP;
                        end
                        CMD_ALLOC:
                        begin
                            if (free_reg == '0)
                            begin
                                status_next = ST_SHORT;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                waddr_next = hint_reg;
                                base_next  = hint_base_reg;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_MARK, CMD_RELEASE, CMD_TEST:
                        begin
                            if (out_of_range)
                            begin
                                status_next = ST_RANGE;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                state_next = S_DIV;
                            end
                        end
                        CMD_ENOUGH:
                        begin
                            status_next = enough ? ST_OK : ST_SHORT;
                            state_next  = S_FIN;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_wdata = sweep_pat;
                if (sweep_pat == ALL_ONES && waddr_reg != LAST_WORD)
                begin
                    hint_next      = waddr_reg + AW'(1);
                    hint_base_next = base_reg + WORD_STEP;
                end
                if (waddr_reg == LAST_WORD)
                begin
                    free_next  = FULL_COUNT - lim_reg;
                    init_next  = 1'b0;
                    state_next = init_reg ? S_IDLE : S_FIN;
                end
                else
                begin
                    waddr_next = waddr_reg + AW'(1);
                    base_next  = base_reg + WORD_STEP;
                end
            end
            S_SCAN:
            begin
                if (word_pad == ALL_ONES)
                begin
                    if (waddr_reg == LAST_WORD)
                    begin
                        status_next = ST_SHORT;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        mem_raddr  = waddr_reg + AW'(1);
                        waddr_next = waddr_reg + AW'(1);
                        base_next  = base_reg + WORD_STEP;
                    end
                end
                else
                begin
                    mem_we         = 1'b1;
                    mem_wdata      = mem_rdata | low_zero;
                    granted_next   = grant32[IDX_W-1:0];
                    hint_next      = waddr_reg;
                    hint_base_next = base_reg;
                    if (free_reg != '0)
                    begin
                        free_next = free_reg - CW'(1);
                    end
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                q_next     = AW'(prod >> SHIFT);
                state_next = S_BIT_RD;
            end
            S_BIT_RD:
            begin
                mem_raddr  = q_reg;
                bsel_next  = rem32[BW-1:0];
                state_next = S_BIT_MOD;
            end
            S_BIT_MOD:
            begin
                mem_waddr  = q_reg;
                state_next = S_FIN;
                case (cmd_reg)
                    CMD_TEST:
                    begin
                        bitv_next = cur_bit;
                    end
                    CMD_MARK:
                    begin
                        if (!cur_bit)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = mem_rdata | bit_mask;
                            if (free_reg != '0)
                            begin
                                free_next = free_reg - CW'(1);
                            end
                        end
                    end
                    default:
                    begin
                        if (cur_bit)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = mem_rdata & ~bit_mask;
                            if (free_reg < FULL_COUNT)
                            begin
                                free_next = free_reg + CW'(1);
                            end
                            if (q_reg < hint_reg)
                            begin
                                hint_next      = q_reg;
                                hint_base_next = rel_base32[BASE_W-1:0];
                            end
                        end
                    end
                endcase
            end
            S_FIN:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            init_reg      <= 1'b1;
            lim_reg       <= '0;
            waddr_reg     <= '0;
            base_reg      <= '0;
            hint_reg      <= '0;
            hint_base_reg <= '0;
            free_reg      <= FULL_COUNT;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            lim_reg       <= lim_next;
            waddr_reg     <= waddr_next;
            base_reg      <= base_next;
            hint_reg      <= hint_next;
            hint_base_reg <= hint_base_next;
            free_reg      <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        idx_reg     <= idx_next;
        q_reg       <= q_next;
        bsel_reg    <= bsel_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        bitv_reg    <= bitv_next;
    end

endmodule

### rtl/core/bitmap_block_allocator.sv
// Command flow: check-enough, range errors and unused codes go straight to the
// result state; mark, release and test pass through divide, bit-read and
// bit-modify states; allocate scans from a lowest-free hint, one map word per
// cycle; format writes one map word per cycle. One command at a time. After
// reset the map is cleared by a pass over all MAP_WORDS words (4096 by default)
// during which in_stall stays high; config writes are taken.
// ---------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit free-block bitmap allocator: used/free map in a RAM, running free
// count, format/allocate/mark/release/test/check-enough commands.
// ---------------------------------------------------------------------------
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = 131072,
    parameter int WORD_BITS  = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [CMD_W-1:0] cmd,
    input  logic [IDX_W-1:0] block_index,
    input  logic [CNT_W-1:0] required_count,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [ST_W-1:0]  status,
    output logic [IDX_W-1:0] allocated_index,
    output logic             bit_value,
    output logic [CNT_W-1:0] free_blocks,
    input  logic             cfg_write,
    input  logic [CNT_W-1:0] cfg_data
);

    localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic [CNT_W-1:0]     reserved_reg;
    logic                 out_valid_reg;
    result_t              out_res_reg;

    item_t                item;
    result_t              res;
    logic                 res_valid;
    logic                 res_ready;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    assign item.cmd            = cmd;
    assign item.block_index    = block_index;
    assign item.required_count = required_count;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    bba_ctrl #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .WORD_BITS  (WORD_BITS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .item            (item),
        .reserved_blocks (reserved_reg),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata)
    );

    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg  <= RESERVED_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                reserved_reg <= cfg_data;
            end
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_res_reg.status;
    assign allocated_index = out_res_reg.allocated_index;
    assign bit_value       = out_res_reg.bit_value;
    assign free_blocks     = out_res_reg.free_blocks;

    a_range_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_RANGE |-> allocated_index == '0 && !bit_value)
        else $error("range error beat carries grant or bit");

    a_bit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bit_value |-> status == ST_OK)
        else $error("used bit reported with error status");

    a_idle_no_res: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !res_valid)
        else $error("sequencer accepting while holding a result");

    a_res_load: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> out_valid)
        else $error("result not loaded into output register");

endmodule
